### rtl/atlas_shelf_packer_defines.svh
// Assertion macros for the shelf packer. They expand to nothing in synthesis.
`ifndef ATLAS_SHELF_PACKER_DEFINES_SVH
`define ATLAS_SHELF_PACKER_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge out of reset
`define ASP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASP_ASSERT_ALWAYS(lbl, expr, msg)
`define ASP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/asp_pkg.sv
package asp_pkg;

  // Field and register widths
  localparam int BOX_W   = 12;
  localparam int POS_W   = 12;
  localparam int REG_W   = 13;
  localparam int FILL_W  = 14;
  localparam int CFG_IDX_W = 8;

  // Shelf heights are rounded up to this granule (mask of low bits)
  localparam logic [REG_W-1:0] ROUND_MASK = 13'd7;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ATLAS_WIDTH  = 8'd0,
    CFG_ATLAS_HEIGHT = 8'd1
  } cfg_idx_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // One shelf table entry
  typedef struct packed {
    logic [FILL_W-1:0] fill_x;
    logic [REG_W-1:0]  top_y;
    logic [REG_W-1:0]  height;
  } shelf_t;

endpackage

### rtl/asp_in_if.sv
interface asp_in_if import asp_pkg::*;;
  logic             valid;
  logic             ready;
  logic [BOX_W-1:0] box_width;
  logic [BOX_W-1:0] box_height;

  modport source (output valid, box_width, box_height, input ready);
  modport sink   (input valid, box_width, box_height, output ready);
endinterface

### rtl/asp_out_if.sv
interface asp_out_if import asp_pkg::*;;
  logic             valid;
  logic             ready;
  logic             placed;
  logic [POS_W-1:0] pos_x;
  logic [POS_W-1:0] pos_y;
  logic             table_full;

  modport source (output valid, placed, pos_x, pos_y, table_full, input ready);
  modport sink   (input valid, placed, pos_x, pos_y, table_full, output ready);
endinterface

### rtl/asp_cfg_if.sv
interface asp_cfg_if import asp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [REG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/atlas_shelf_packer.sv
// Shelf packer for a 2D texture atlas. Each request (box_width, box_height) gets one result:
// the box position, or placed=0 when the atlas height is exhausted, with table_full=1 when
// instead all MAX_SHELVES shelves are in use. Heights round up to a multiple of 8; a box goes
// on the first shelf of that exact height with room for width plus a 1-pixel gap, else on a
// new shelf 1 pixel below the last one. Shelves live in a single-port-read synchronous RAM
// scanned one entry per cycle up to the first matching shelf or the last one; an empty
// table skips the scan. While a stalled sink still holds a result, the next result is not
// written. Requests are handled one at a time; a result waits in the output register
// without blocking the next accept. No RAM clearing is needed after reset. Registers: 0
// atlas_width, 1 atlas_height (reset 512 each), to be written only while the block is idle;
// other indexes are ignored.
`include "atlas_shelf_packer_defines.svh"

module atlas_shelf_packer import asp_pkg::*; #(
  parameter int MAX_SHELVES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  asp_cfg_if.sink   cfg_ch,
  asp_in_if.sink    in_ch,
  asp_out_if.source out_ch
);

  localparam int AW = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
  localparam int CW = $clog2(MAX_SHELVES + 1);

  // Configuration registers
  logic [REG_W-1:0] atlas_width_r;
  logic [REG_W-1:0] atlas_height_r;

  // Control state
  state_t           state_r, state_nxt;
  logic [CW-1:0]    shelf_count_r, shelf_count_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]    chk_idx_r, chk_idx_nxt;
  logic             hit_r, hit_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Request and hit payload
  logic [BOX_W-1:0]  box_w_r, box_w_nxt;
  logic [REG_W-1:0]  rnd_h_r, rnd_h_nxt;
  logic [AW-1:0]     hit_idx_r, hit_idx_nxt;
  logic [FILL_W-1:0] hit_fill_r, hit_fill_nxt;
  logic [FILL_W-1:0] new_fill_r, new_fill_nxt;
  logic [REG_W-1:0]  hit_top_r, hit_top_nxt;
  logic [REG_W+1:0]  last_next_top_r, last_next_top_nxt;

  // Output payload
  logic             out_placed_r, out_placed_nxt;
  logic [POS_W-1:0] out_x_r, out_x_nxt;
  logic [POS_W-1:0] out_y_r, out_y_nxt;
  logic             out_full_r, out_full_nxt;

  // Shelf RAM
  shelf_t        shelf_mem [MAX_SHELVES];
  shelf_t        rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  shelf_t        wr_data;

  // Datapath helpers
  logic [REG_W-1:0]  in_rnd_h;
  logic [FILL_W:0]   scan_end;
  logic              scan_match;
  logic [CW-1:0]     chk_idx_ext;
  logic [CW-1:0]     idx_ext;
  logic              in_xfer;
  logic              out_free;
  logic [REG_W+1:0]  new_top;
  logic [REG_W+2:0]  new_bottom;
  logic              height_fail;
  logic              count_full;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.placed     = out_placed_r;
  assign out_ch.pos_x      = out_x_r;
  assign out_ch.pos_y      = out_y_r;
  assign out_ch.table_full = out_full_r;

  // Round the requested height up to a multiple of 8
  assign in_rnd_h = (REG_W'(in_ch.box_height) + ROUND_MASK) & ~ROUND_MASK;

  // Fit test on the entry read last cycle
  assign scan_end   = (FILL_W+1)'(rd_data_r.fill_x) + (FILL_W+1)'(box_w_r) + (FILL_W+1)'(1);
  assign scan_match = (rd_data_r.height == rnd_h_r)
                      && (scan_end <= (FILL_W+1)'(atlas_width_r));

  assign chk_idx_ext = CW'(chk_idx_r);
  assign idx_ext     = CW'(idx_r);
  assign rd_addr     = idx_r;

  // New shelf placement and its checks
  assign new_top     = (shelf_count_r == '0) ? '0 : (REG_W+2)'(last_next_top_r);
  assign new_bottom  = (REG_W+3)'(new_top) + (REG_W+3)'(rnd_h_r);
  assign height_fail = (shelf_count_r != '0) && (new_bottom > (REG_W+3)'(atlas_height_r));
  assign count_full  = (shelf_count_r == CW'(MAX_SHELVES));

  // Next-state logic
  always_comb begin
    state_nxt         = state_r;
    shelf_count_nxt   = shelf_count_r;
    idx_nxt           = idx_r;
    chk_vld_nxt       = chk_vld_r;
    chk_idx_nxt       = chk_idx_r;
    hit_nxt           = hit_r;
    out_valid_nxt     = out_valid_r;
    box_w_nxt         = box_w_r;
    rnd_h_nxt         = rnd_h_r;
    hit_idx_nxt       = hit_idx_r;
    hit_fill_nxt      = hit_fill_r;
    new_fill_nxt      = new_fill_r;
    hit_top_nxt       = hit_top_r;
    last_next_top_nxt = last_next_top_r;
    out_placed_nxt    = out_placed_r;
    out_x_nxt         = out_x_r;
    out_y_nxt         = out_y_r;
    out_full_nxt      = out_full_r;
    mem_we            = 1'b0;
    wr_addr           = '0;
    wr_data           = '0;

    // Result register drains on transfer
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          box_w_nxt   = in_ch.box_width;
          rnd_h_nxt   = in_rnd_h;
          idx_nxt     = '0;
          chk_vld_nxt = 1'b0;
          hit_nxt     = 1'b0;
          state_nxt   = (shelf_count_r == '0) ? ST_EMIT : ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle, compare the previous one
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = idx_r;
        if (idx_ext + CW'(1) < shelf_count_r) begin
          idx_nxt = idx_r + AW'(1);
        end
        if (chk_vld_r) begin
          if (scan_match) begin
            hit_nxt      = 1'b1;
            hit_idx_nxt  = chk_idx_r;
            hit_fill_nxt = rd_data_r.fill_x;
            hit_top_nxt  = rd_data_r.top_y;
            new_fill_nxt = scan_end[FILL_W-1:0];
            state_nxt    = ST_EMIT;
          end else if (chk_idx_ext + CW'(1) == shelf_count_r) begin
            state_nxt = ST_EMIT;
          end
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          priority if (hit_r) begin
            out_placed_nxt = 1'b1;
            out_x_nxt      = hit_fill_r[POS_W-1:0];
            out_y_nxt      = hit_top_r[POS_W-1:0];
            out_full_nxt   = 1'b0;
            mem_we         = 1'b1;
            wr_addr        = hit_idx_r;
            wr_data        = '{fill_x: new_fill_r, top_y: hit_top_r, height: rnd_h_r};
          end else if (height_fail) begin
            out_placed_nxt = 1'b0;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_full_nxt   = 1'b0;
          end else if (count_full) begin
            out_placed_nxt = 1'b0;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_full_nxt   = 1'b1;
          end else begin
            // Open a new shelf with the box at its left end
            out_placed_nxt    = 1'b1;
            out_x_nxt         = '0;
            out_y_nxt         = new_top[POS_W-1:0];
            out_full_nxt      = 1'b0;
            mem_we            = 1'b1;
            wr_addr           = shelf_count_r[AW-1:0];
            wr_data           = '{fill_x: FILL_W'(box_w_r) + FILL_W'(1),
                                  top_y:  new_top[REG_W-1:0],
                                  height: rnd_h_r};
            shelf_count_nxt   = shelf_count_r + CW'(1);
            last_next_top_nxt = (REG_W+2)'(new_top[REG_W-1:0]) + (REG_W+2)'(rnd_h_r)
                                + (REG_W+2)'(1);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      shelf_count_r  <= '0;
      chk_vld_r      <= 1'b0;
      hit_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      atlas_width_r  <= 13'd512;
      atlas_height_r <= 13'd512;
    end else begin
      state_r       <= state_nxt;
      shelf_count_r <= shelf_count_nxt;
      chk_vld_r     <= chk_vld_nxt;
      hit_r         <= hit_nxt;
      out_valid_r   <= out_valid_nxt;
      // Configuration writes
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_ATLAS_WIDTH) begin
          atlas_width_r <= cfg_ch.data;
        end else if (cfg_ch.index == CFG_ATLAS_HEIGHT) begin
          atlas_height_r <= cfg_ch.data;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r           <= idx_nxt;
    chk_idx_r       <= chk_idx_nxt;
    box_w_r         <= box_w_nxt;
    rnd_h_r         <= rnd_h_nxt;
    hit_idx_r       <= hit_idx_nxt;
    hit_fill_r      <= hit_fill_nxt;
    new_fill_r      <= new_fill_nxt;
    hit_top_r       <= hit_top_nxt;
    last_next_top_r <= last_next_top_nxt;
    out_placed_r    <= out_placed_nxt;
    out_x_r         <= out_x_nxt;
    out_y_r         <= out_y_nxt;
    out_full_r      <= out_full_nxt;
  end

  // Shelf RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shelf_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= shelf_mem[rd_addr];
  end

  // Checks
  `ASP_ASSERT_ALWAYS(a_count_bound, shelf_count_r <= CW'(MAX_SHELVES), "shelf count overflow")
  `ASP_ASSERT_ALWAYS(a_flags_excl, !out_valid_r || !(out_placed_r && out_full_r), "placed with table_full")
  `ASP_ASSERT_NEXT(a_count_only_emit, state_r != ST_EMIT, $stable(shelf_count_r), "count moved outside emit")
  `ASP_ASSERT_ALWAYS(a_scan_nonempty, state_r != ST_SCAN || shelf_count_r != '0, "scan with empty table")

endmodule

### tb/atlas_shelf_packer_tb.sv
`timescale 1ns / 100ps

module atlas_shelf_packer_tb;
  import asp_pkg::*;

  localparam int SHELF_SLOTS = 64;
  localparam int GAP_PX = 1;
  localparam int RESET_DIM = 512;
  localparam logic [REG_W-1:0] REG_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 8'd2;
  localparam int TOP_MASK = (1 << REG_W) - 1;
  localparam int FILL_MASK = (1 << FILL_W) - 1;

  typedef struct packed {
    logic [BOX_W-1:0] w;
    logic [BOX_W-1:0] h;
  } box_t;

  typedef struct packed {
    logic             placed;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             table_full;
  } spot_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  asp_cfg_if cfg_ch ();
  asp_in_if  in_ch ();
  asp_out_if out_ch ();

  atlas_shelf_packer #(.MAX_SHELVES(SHELF_SLOTS)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the atlas registers and shelf table
  int unsigned atlas_w_reg = RESET_DIM;
  int unsigned atlas_h_reg = RESET_DIM;
  int unsigned fill_col [SHELF_SLOTS];
  int unsigned top_row [SHELF_SLOTS];
  int unsigned shelf_ht [SHELF_SLOTS];
  int unsigned shelves_open = 0;

  box_t  pending_boxes [$];
  spot_t expected_spots [$];

  int boxes_issued = 0;
  int boxes_taken = 0;
  int results_seen = 0;
  int placed_cnt = 0;
  int height_refused = 0;
  int table_refused = 0;
  int cfg_writes = 0;
  int errors = 0;

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int   in_gap = 0;
  int   out_stall = 0;
  logic in_rush = 1'b0;
  logic out_rush = 1'b0;
  box_t next_box;

  // Shelf placement: first matching shelf with room, else open a new one below the last
  function automatic spot_t place_box(logic [BOX_W-1:0] w, logic [BOX_W-1:0] h);
    spot_t       res;
    int unsigned rh;
    int unsigned top;
    int unsigned i;
    res = '0;
    rh = (int'(h) + int'(ROUND_MASK)) & ~int'(ROUND_MASK);
    for (i = 0; i < shelves_open; i++) begin
      if (shelf_ht[i] == rh && fill_col[i] + w + GAP_PX <= atlas_w_reg) begin
        res.placed = 1'b1;
        res.pos_x = POS_W'(fill_col[i]);
        res.pos_y = POS_W'(top_row[i]);
        fill_col[i] = (fill_col[i] + w + GAP_PX) & FILL_MASK;
        return res;
      end
    end
    top = 0;
    if (shelves_open > 0) begin
      top = top_row[shelves_open-1] + shelf_ht[shelves_open-1] + GAP_PX;
      // height is checked before table capacity
      if (top + rh > atlas_h_reg) return res;
    end
    if (shelves_open >= SHELF_SLOTS) begin
      res.table_full = 1'b1;
      return res;
    end
    top_row[shelves_open] = top & TOP_MASK;
    shelf_ht[shelves_open] = rh & TOP_MASK;
    fill_col[shelves_open] = (w + GAP_PX) & FILL_MASK;
    shelves_open++;
    res.placed = 1'b1;
    res.pos_y = POS_W'(top);
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got_v, logic [31:0] want_v);
    $display("MISMATCH at %0t, result %0d: %s got %0h want %0h",
             $realtime, results_seen, what, got_v, want_v);
    errors++;
  endtask

  task automatic queue_box(int w, int h);
    box_t b;
    b.w = BOX_W'(w);
    b.h = BOX_W'(h);
    pending_boxes = {pending_boxes, b};
    boxes_issued++;
  endtask

  // Mostly boxes in a few shelf height classes, some full range noise
  task automatic queue_random(int n, int max_class, int w_cap, int tall_odds);
    int cls;
    int w;
    int h;
    repeat (n) begin
      cls = $urandom_range(0, max_class);
      h = (cls == 0) ? 0 : cls * 8 - int'($urandom_range(0, 7));
      w = $urandom_range(0, w_cap);
      if ($urandom_range(0, 15) == 0) w = $urandom_range(0, 4095);
      if (tall_odds != 0 && $urandom_range(1, tall_odds) == 1) h = $urandom_range(0, 4095);
      queue_box(w, h);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_ATLAS_WIDTH:  atlas_w_reg = value;
      CFG_ATLAS_HEIGHT: atlas_h_reg = value;
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued box is in and every result is out
  task automatic settle();
    while (boxes_taken != boxes_issued || expected_spots.size() != 0) @(posedge clk);
  endtask

  // Box driver: one item per transfer, random gap before the next
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && !in_taken) begin
        // holding until the transfer completes
      end else if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_boxes.size() != 0) begin
        next_box = pending_boxes.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.box_width  <= next_box.w;
        in_ch.box_height <= next_box.h;
        if ($urandom_range(0, 31) == 0) in_rush = !in_rush;
        in_gap = in_rush ? 0 : $urandom_range(0, 7);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result sink: random stall after each transfer
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 31) == 0) out_rush = !out_rush;
        out_stall = out_rush ? 0 : $urandom_range(0, 7);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each box transfer, check each result transfer
  always @(posedge clk) begin
    spot_t want;
    spot_t got;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (in_taken) begin
      want = place_box(in_ch.box_width, in_ch.box_height);
      if (want.placed) placed_cnt++;
      else if (want.table_full) table_refused++;
      else height_refused++;
      expected_spots = {expected_spots, want};
      boxes_taken++;
    end
    if (out_taken) begin
      got.placed = out_ch.placed;
      got.pos_x = out_ch.pos_x;
      got.pos_y = out_ch.pos_y;
      got.table_full = out_ch.table_full;
      if (expected_spots.size() == 0) begin
        report("result with no request outstanding", 32'(got), '0);
      end else begin
        want = expected_spots.pop_front();
        if (got.placed !== want.placed)
          report("placed", 32'(got.placed), 32'(want.placed));
        if (got.pos_x !== want.pos_x) report("pos_x", 32'(got.pos_x), 32'(want.pos_x));
        if (got.pos_y !== want.pos_y) report("pos_y", 32'(got.pos_y), 32'(want.pos_y));
        if (got.table_full !== want.table_full)
          report("table_full", 32'(got.table_full), 32'(want.table_full));
      end
      results_seen++;
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.box_width = '0;
    in_ch.box_height = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // unknown register index must leave both dimensions alone
    write_reg(CFG_IDX_SPARE, REG_MAX);

    // reset dimensions: zero sizes, oversize first box, exact fit, height refusal
    queue_box(0, 0);
    queue_box(0, 0);
    queue_box(4095, 1);
    queue_box(1, 8);
    queue_box(10, 5);
    queue_box(500, 4095);
    queue_box(510, 7);
    queue_box(0, 8);
    queue_box(497, 8);
    queue_box(0, 8);
    queue_box(4095, 4095);
    queue_box(0, 3);
    settle();

    // widest atlas: column and row positions past 4095 wrap in the result
    write_reg(CFG_ATLAS_WIDTH, REG_MAX);
    write_reg(CFG_ATLAS_HEIGHT, REG_MAX);
    queue_box(4095, 4095);
    queue_box(0, 4090);
    queue_box(3, 1000);
    queue_box(8, 1);
    settle();

    // one-pixel width: every box opens a shelf until the table fills
    write_reg(CFG_ATLAS_WIDTH, 13'd1);
    queue_random(90, 4, 4095, 0);
    settle();

    write_reg(CFG_ATLAS_WIDTH, 13'd4096);
    queue_random(130, 4, 255, 16);
    settle();

    // one-pixel height: new shelves refused on height before table capacity
    write_reg(CFG_ATLAS_WIDTH, REG_MAX);
    write_reg(CFG_ATLAS_HEIGHT, 13'd1);
    queue_random(90, 6, 4095, 8);
    settle();

    write_reg(CFG_ATLAS_WIDTH, 13'd512);
    write_reg(CFG_ATLAS_HEIGHT, 13'd4096);
    queue_random(100, 4, 127, 16);
    settle();

    write_reg(CFG_ATLAS_WIDTH, REG_W'($urandom_range(1, REG_MAX)));
    write_reg(CFG_ATLAS_HEIGHT, REG_W'($urandom_range(1, REG_MAX)));
    queue_random(90, 8, 1023, 4);
    settle();

    // let any stray result show up
    repeat (80) @(posedge clk);
    if (expected_spots.size() != 0) report("results never delivered", expected_spots.size(), 0);

    $display("summary: %0d boxes sent, %0d placed, %0d refused on height, %0d on full table",
             boxes_taken, placed_cnt, height_refused, table_refused);
    $display("summary: %0d shelves opened, %0d register writes, %0d mismatches",
             shelves_open, cfg_writes, errors);
    if (errors == 0) begin
      $display("atlas_shelf_packer_tb: done, clean");
    end else begin
      $display("atlas_shelf_packer_tb: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout: %0d of %0d boxes taken, %0d results", boxes_taken, boxes_issued,
             results_seen);
    $display("atlas_shelf_packer_tb: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/asp_pkg.sv
rtl/asp_in_if.sv
rtl/asp_out_if.sv
rtl/asp_cfg_if.sv
rtl/atlas_shelf_packer.sv
tb/atlas_shelf_packer_tb.sv
